@@ rtl/wzad_pkg.sv @@
`default_nettype none

package wzad_pkg;

    localparam int SAMPLE_W = 24;
    localparam int DEV_IDX_W = 4;
    localparam int SUM_W = 32;
    localparam int SQ_W = 53;
    localparam int CNT_W = 7;
    // squared sums and the scaled variance term, with room for the factor of nine
    localparam int PROD_W = 66;
    localparam int SAMPLE_SQ_W = 2 * SAMPLE_W;
    localparam int SUM_SQ_W = 2 * SUM_W;

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [SQ_W-1:0]         sq;
        logic [CNT_W-1:0]        fill;
        logic [CNT_W-1:0]        ptr;
    } wzad_dev_state_t;

endpackage

`default_nettype wire

@@ rtl/wzad_sample_mem.sv @@
`default_nettype none

module wzad_sample_mem
    import wzad_pkg::*;
#(
    parameter int DEPTH = 1600,
    parameter int ADDR_W = 11
)
(
    input  wire logic                       clk,
    input  wire logic                       rd_en,
    input  wire logic [ADDR_W-1:0]          rd_addr,
    output logic signed [SAMPLE_W-1:0]      rd_data,
    input  wire logic                       we,
    input  wire logic [ADDR_W-1:0]          wr_addr,
    input  wire logic signed [SAMPLE_W-1:0] wr_data
);

    logic signed [SAMPLE_W-1:0] mem [DEPTH];
    logic signed [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

@@ rtl/wzad_dev_mem.sv @@
`default_nettype none

module wzad_dev_mem
    import wzad_pkg::*;
#(
    parameter int NUM_DEVICES = 16,
    parameter int DEV_W = 4
)
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            rd_en,
    input  wire logic [DEV_W-1:0] rd_addr,
    output wzad_dev_state_t      rd_data,
    input  wire logic            we,
    input  wire logic [DEV_W-1:0] wr_addr,
    input  wire wzad_dev_state_t wr_data
);

    wzad_dev_state_t        mem [NUM_DEVICES];
    wzad_dev_state_t        rd_data_reg;
    logic                   rd_valid_reg;
    logic [NUM_DEVICES-1:0] valid_reg;

    // an entry never written since reset reads as all zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

@@ rtl/window_zscore_anomaly_detector_top.sv @@
// An accepted request runs state read, old sample, sums, variance and done
// once the device window is full, state read and done while it fills or for
// a device index out of range. A new request is taken only when idle, so the
// read-modify-write of the device state and sample memories ends before it.
// Reset: per-device sums, counts and pointers read as zero after reset;
// sample memory contents are not cleared.
`default_nettype none

module window_zscore_anomaly_detector_top
    import wzad_pkg::*;
#(
    parameter int WINDOW = 100,
    parameter int NUM_DEVICES = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // [23:0] sample_value
    input  wire logic [3:0]  s_axis_tuser,  // [3:0] device_index
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,  // [0] window_checked, [1] anomaly_flag, [7:2] zero
    output logic [3:0]       m_axis_tuser   // [3:0] device_echo
);

    localparam int DEPTH = NUM_DEVICES * WINDOW;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int DEV_W = (NUM_DEVICES > 1) ? $clog2(NUM_DEVICES) : 1;
    localparam logic [CNT_W-1:0] WIN_CNT = CNT_W'(WINDOW);
    localparam logic [CNT_W-1:0] WIN_LAST = CNT_W'(WINDOW - 1);
    localparam logic signed [SUM_W-1:0] WIN_S = SUM_W'(WINDOW);
    localparam logic [PROD_W-1:0] WIN_P = PROD_W'(WINDOW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDST = 3'd1;
    localparam logic [2:0] S_OLD  = 3'd2;
    localparam logic [2:0] S_SUMS = 3'd3;
    localparam logic [2:0] S_VAR  = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    logic                          in_fire;
    logic                          out_free;
    logic                          dev_ok_in;
    logic signed [SAMPLE_W-1:0]    x_in;
    logic signed [SAMPLE_SQ_W-1:0] x_in_sq;

    logic [DEV_IDX_W-1:0]       dev_reg;
    logic                       dev_ok_reg;
    logic signed [SAMPLE_W-1:0] x_reg;
    logic [SQ_W-1:0]            xsq_reg;
    logic                       chk_reg;
    logic [ADDR_W-1:0]          addr_reg;

    logic signed [SAMPLE_SQ_W-1:0] old_sq_full;
    logic [SQ_W-1:0]               old_sq_reg;
    logic signed [SUM_W-1:0]       sum_upd;
    logic signed [SUM_W-1:0]       sum_reg;
    logic [SQ_W-1:0]               sq_upd;
    logic [SQ_W-1:0]               sq_reg;
    logic signed [SUM_SQ_W-1:0]    ss_full;
    logic signed [SUM_SQ_W-1:0]    ss_reg;
    logic signed [SUM_W-1:0]       dev_diff;
    logic signed [SUM_W-1:0]       d_reg;
    logic signed [SUM_SQ_W-1:0]    d_sq_full;
    logic signed [SUM_SQ_W-1:0]    dsq_reg;
    logic signed [PROD_W-1:0]      var_next;
    logic signed [PROD_W-1:0]      var_reg;
    logic signed [PROD_W-1:0]      limit;
    logic                          anomaly;

    logic                       full;
    logic [CNT_W-1:0]           slot;
    logic [ADDR_W-1:0]          addr_cur;
    logic [CNT_W-1:0]           ptr_adv;

    logic                       m_valid_reg;
    logic [DEV_IDX_W-1:0]       m_dev_reg;
    logic                       m_chk_reg;
    logic                       m_anom_reg;

    logic                       smp_rd_en;
    logic                       smp_we;
    logic [ADDR_W-1:0]          smp_waddr;
    logic signed [SAMPLE_W-1:0] smp_rd_data;

    logic                       st_rd_en;
    logic                       st_we;
    wzad_dev_state_t            st_rd;
    wzad_dev_state_t            st_wdata;

    assign x_in = $signed(s_axis_tdata[SAMPLE_W-1:0]);
    assign x_in_sq = x_in * x_in;
    assign dev_ok_in = (32'(s_axis_tuser) < 32'(NUM_DEVICES));
    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    // slot and memory address from the device state just read
    assign full = (st_rd.fill >= WIN_CNT);
    assign slot = full ? st_rd.ptr : st_rd.fill;
    assign addr_cur = ADDR_W'(DEV_W'(dev_reg)) * ADDR_W'(WINDOW) + ADDR_W'(slot);
    assign ptr_adv = (st_rd.ptr == WIN_LAST) ? '0 : st_rd.ptr + 1'b1;

    assign old_sq_full = smp_rd_data * smp_rd_data;
    assign sum_upd = st_rd.sum - SUM_W'(smp_rd_data) + SUM_W'(x_reg);
    assign sq_upd = st_rd.sq - old_sq_reg + xsq_reg;
    assign ss_full = sum_reg * sum_reg;
    assign dev_diff = WIN_S * SUM_W'(x_reg) - sum_reg;
    assign d_sq_full = d_reg * d_reg;
    assign var_next = $signed(PROD_W'(sq_reg) * WIN_P) - PROD_W'(ss_reg);

    // deviation squared against nine times the scaled variance
    assign limit = (var_reg <<< 3) + var_reg;
    assign anomaly = chk_reg && !var_reg[PROD_W-1] && (var_reg != '0)
                     && (PROD_W'(dsq_reg) > limit);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_RDST;
                end
            end
            S_RDST:
            begin
                state_next = (dev_ok_reg && full) ? S_OLD : S_DONE;
            end
            S_OLD:
            begin
                state_next = S_SUMS;
            end
            S_SUMS:
            begin
                state_next = S_VAR;
            end
            S_VAR:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        smp_rd_en = (state_reg == S_RDST) && dev_ok_reg && full;
        smp_we = 1'b0;
        smp_waddr = addr_cur;
        st_rd_en = in_fire && dev_ok_in;
        st_we = 1'b0;
        st_wdata = st_rd;
        if ((state_reg == S_RDST) && dev_ok_reg && !full)
        begin
            smp_we = 1'b1;
            st_we = 1'b1;
            st_wdata.sum = st_rd.sum + SUM_W'(x_reg);
            st_wdata.sq = st_rd.sq + xsq_reg;
            st_wdata.fill = st_rd.fill + 1'b1;
        end
        else if (state_reg == S_OLD)
        begin
            smp_we = 1'b1;
            smp_waddr = addr_reg;
        end
        else if (state_reg == S_SUMS)
        begin
            st_we = 1'b1;
            st_wdata.sum = sum_reg;
            st_wdata.sq = sq_upd;
            st_wdata.ptr = ptr_adv;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == S_DONE) && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            dev_reg <= s_axis_tuser;
            dev_ok_reg <= dev_ok_in;
            x_reg <= x_in;
            xsq_reg <= SQ_W'($unsigned(x_in_sq));
        end
        if (state_reg == S_RDST)
        begin
            chk_reg <= dev_ok_reg && full;
            addr_reg <= addr_cur;
        end
        if (state_reg == S_OLD)
        begin
            old_sq_reg <= SQ_W'($unsigned(old_sq_full));
            sum_reg <= sum_upd;
        end
        if (state_reg == S_SUMS)
        begin
            sq_reg <= sq_upd;
            ss_reg <= ss_full;
            d_reg <= dev_diff;
        end
        if (state_reg == S_VAR)
        begin
            var_reg <= var_next;
            dsq_reg <= d_sq_full;
        end
        if ((state_reg == S_DONE) && out_free)
        begin
            m_dev_reg <= dev_reg;
            m_chk_reg <= chk_reg;
            m_anom_reg <= anomaly;
        end
    end

    wzad_sample_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_sample_mem (
        .clk     (clk),
        .rd_en   (smp_rd_en),
        .rd_addr (addr_cur),
        .rd_data (smp_rd_data),
        .we      (smp_we),
        .wr_addr (smp_waddr),
        .wr_data (x_reg)
    );

    wzad_dev_mem #(
        .NUM_DEVICES (NUM_DEVICES),
        .DEV_W       (DEV_W)
    ) u_dev_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (st_rd_en),
        .rd_addr (DEV_W'(s_axis_tuser)),
        .rd_data (st_rd),
        .we      (st_we),
        .wr_addr (DEV_W'(dev_reg)),
        .wr_data (st_wdata)
    );

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata = {6'b0, m_anom_reg, m_chk_reg};
    assign m_axis_tuser = m_dev_reg;

`ifndef SYNTHESIS
    a_accept_reads_state: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_RDST))
        else $error("accepted request did not move to state read");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        st_we |-> ((st_wdata.fill <= WIN_CNT) && (st_wdata.ptr < WIN_CNT)))
        else $error("device fill count or pointer out of window range");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_valid_reg) |-> ($past(state_reg) == S_DONE))
        else $error("result raised outside done state");

    a_sample_write_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OLD) |-> ($past(smp_rd_en) && (smp_waddr == $past(addr_cur))))
        else $error("sample write-back address does not match the read");
`endif

endmodule

`default_nettype wire
